/* hdl/peak_neighbourhood_centroid_core_macros.svh */
// Assertion helpers for the peak neighbourhood centroid core.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PEAK_NEIGHBOURHOOD_CENTROID_CORE_MACROS_SVH
`define PEAK_NEIGHBOURHOOD_CENTROID_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PNC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PNC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/pnc_pkg.sv */
package pnc_pkg;

	// Field and accumulator widths.
	localparam int PIXEL_BITS    = 16;
	localparam int FRACTION_BITS = 8;
	localparam int POS_BITS      = 12;
	localparam int WIDTH_BITS    = 13;
	localparam int WSUM_BITS     = 21;
	localparam int PSUM_BITS     = 33;
	localparam int OUT_BITS      = 20;
	localparam int PROD_BITS     = PIXEL_BITS + POS_BITS;
	localparam int SCALE_BITS    = PIXEL_BITS + 6;
	localparam int DIVIDEND_BITS = PSUM_BITS + FRACTION_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

	// Configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_VALUE  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_X      = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_Y      = 2'd3;

	localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 13'd1024;

	// 50*pixel >= 49*peak is the exact integer form of pixel >= 0.98*peak.
	localparam int VALUE_NUM = 50;
	localparam int VALUE_DEN = 49;

	// A squared distance below 9 holds exactly when both offsets lie within two.
	localparam int NEIGHBOUR_REACH = 2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // a request is taken this cycle
		logic load;     // copy the sums into the divider and clear them
		logic step;     // one quotient bit
		logic publish;  // move the quotients into the output register
	} pnc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_acc;  // the last pixel of the frame is being summed
		logic div_last;  // the current step produces the final quotient bit
		logic out_free;  // the output register can take a result
	} pnc_status_t;

endpackage

/* hdl/pnc_controller.sv */
module pnc_controller import pnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        end_of_frame,
	output logic        in_stall,
	input  pnc_status_t status,
	output pnc_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_ACCUM   = 5'b00001,
		ST_DRAIN   = 5'b00010,
		ST_LOAD    = 5'b00100,
		ST_DIVIDE  = 5'b01000,
		ST_DELIVER = 5'b10000
	} pnc_state_t;

	pnc_state_t state_q;
	pnc_state_t state_d;

	// Pixels are only taken while the frame is being summed.
	assign in_stall = (state_q != ST_ACCUM);

	// Command decode.
	always_comb begin
		cmd.accept  = in_valid && (state_q == ST_ACCUM);
		cmd.load    = (state_q == ST_LOAD);
		cmd.step    = (state_q == ST_DIVIDE);
		cmd.publish = (state_q == ST_DELIVER) && status.out_free;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (in_valid && end_of_frame) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.last_acc) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_last) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (status.out_free) begin
					state_d = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/pnc_datapath.sv */
module pnc_datapath import pnc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pnc_cmd_t                  cmd,
	output pnc_status_t               status,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic                      end_of_frame,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [OUT_BITS-1:0]       centroid_x,
	output logic [OUT_BITS-1:0]       centroid_y,
	output logic                      centroid_valid
);

	localparam logic signed [POS_BITS:0] REACH_POS = (POS_BITS + 1)'(NEIGHBOUR_REACH);

	// Configuration registers.
	logic [WIDTH_BITS-1:0] frame_width_q;
	logic [PIXEL_BITS-1:0] peak_value_q;
	logic [POS_BITS-1:0]   peak_x_q;
	logic [POS_BITS-1:0]   peak_y_q;

	// Raster position.
	logic [POS_BITS-1:0]   col_q;
	logic [POS_BITS-1:0]   row_q;
	logic [WIDTH_BITS-1:0] col_next;
	logic                  row_wrap;

	// Selection of counted pixels.
	logic [SCALE_BITS-1:0]      scaled_pix;
	logic [SCALE_BITS-1:0]      scaled_peak;
	logic signed [POS_BITS:0]   dx;
	logic signed [POS_BITS:0]   dy;
	logic                       counted;

	// Pipeline stages.
	logic                  vld_s1;
	logic                  last_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [POS_BITS-1:0]   col_s1;
	logic [POS_BITS-1:0]   row_s1;
	logic                  vld_s2;
	logic                  last_s2;
	logic [PIXEL_BITS-1:0] wpix_s2;
	logic [PROD_BITS-1:0]  colp_s2;
	logic [PROD_BITS-1:0]  rowp_s2;

	// Sums.
	logic [WSUM_BITS-1:0] wsum_q;
	logic [PSUM_BITS-1:0] csum_q;
	logic [PSUM_BITS-1:0] rsum_q;

	// Divider.
	logic [DIVIDEND_BITS-1:0] numx_q;
	logic [DIVIDEND_BITS-1:0] numy_q;
	logic [WSUM_BITS-1:0]     den_q;
	logic [WSUM_BITS-1:0]     remx_q;
	logic [WSUM_BITS-1:0]     remy_q;
	logic [DIV_CNT_BITS-1:0]  cnt_q;
	logic [WSUM_BITS:0]       trial_x;
	logic [WSUM_BITS:0]       trial_y;
	logic                     fit_x;
	logic                     fit_y;
	logic [WSUM_BITS-1:0]     remx_d;
	logic [WSUM_BITS-1:0]     remy_d;

	logic out_valid_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			peak_value_q  <= '0;
			peak_x_q      <= '0;
			peak_y_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[WIDTH_BITS-1:0];
				REG_PEAK_VALUE:  peak_value_q  <= cfg_data[PIXEL_BITS-1:0];
				REG_PEAK_X:      peak_x_q      <= cfg_data[POS_BITS-1:0];
				REG_PEAK_Y:      peak_y_q      <= cfg_data[POS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A pixel counts when it is close enough to the peak value and position.
	always_comb begin
		scaled_pix  = SCALE_BITS'(pixel_value) * SCALE_BITS'(VALUE_NUM);
		scaled_peak = SCALE_BITS'(peak_value_q) * SCALE_BITS'(VALUE_DEN);
		dx = $signed({1'b0, peak_x_q}) - $signed({1'b0, col_q});
		dy = $signed({1'b0, peak_y_q}) - $signed({1'b0, row_q});
		counted = (scaled_pix >= scaled_peak)
			&& (dx >= -REACH_POS) && (dx <= REACH_POS)
			&& (dy >= -REACH_POS) && (dy <= REACH_POS);
	end

	// The column wraps at the frame width, and at the largest width supported.
	assign col_next = {1'b0, col_q} + WIDTH_BITS'(1);
	assign row_wrap = (col_next >= frame_width_q) || col_next[POS_BITS];

	// Raster position counters, cleared after the last pixel of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_wrap) begin
				col_q <= '0;
				row_q <= row_q + POS_BITS'(1);
			end else begin
				col_q <= col_next[POS_BITS-1:0];
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.accept;
			vld_s2 <= vld_s1;
		end
	end

	// Stage one holds the gated pixel and its position, stage two the products.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_s1  <= counted ? pixel_value : '0;
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= end_of_frame;
		end
		if (vld_s1) begin
			wpix_s2 <= pix_s1;
			colp_s2 <= PROD_BITS'(pix_s1) * PROD_BITS'(col_s1);
			rowp_s2 <= PROD_BITS'(pix_s1) * PROD_BITS'(row_s1);
			last_s2 <= last_s1;
		end
	end

	// Frame sums, cleared when the divider takes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			csum_q <= '0;
			rsum_q <= '0;
		end else if (cmd.load) begin
			wsum_q <= '0;
			csum_q <= '0;
			rsum_q <= '0;
		end else if (vld_s2) begin
			wsum_q <= wsum_q + WSUM_BITS'(wpix_s2);
			csum_q <= csum_q + PSUM_BITS'(colp_s2);
			rsum_q <= rsum_q + PSUM_BITS'(rowp_s2);
		end
	end

	// Restoring division, one quotient bit per step for both axes.
	always_comb begin
		trial_x = {remx_q, numx_q[DIVIDEND_BITS-1]};
		trial_y = {remy_q, numy_q[DIVIDEND_BITS-1]};
		fit_x   = trial_x >= {1'b0, den_q};
		fit_y   = trial_y >= {1'b0, den_q};
		remx_d  = fit_x ? WSUM_BITS'(trial_x - {1'b0, den_q}) : trial_x[WSUM_BITS-1:0];
		remy_d  = fit_y ? WSUM_BITS'(trial_y - {1'b0, den_q}) : trial_y[WSUM_BITS-1:0];
	end

	// The dividend registers shift the quotient in from the bottom.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			numx_q <= {csum_q, FRACTION_BITS'(0)};
			numy_q <= {rsum_q, FRACTION_BITS'(0)};
			den_q  <= wsum_q;
			remx_q <= '0;
			remy_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.step) begin
			numx_q <= {numx_q[DIVIDEND_BITS-2:0], fit_x};
			numy_q <= {numy_q[DIVIDEND_BITS-2:0], fit_y};
			remx_q <= remx_d;
			remy_q <= remy_d;
			cnt_q  <= cnt_q + DIV_CNT_BITS'(1);
		end
	end

	// Output register; a zero weight sum gives a zero centroid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			centroid_x     <= (den_q != '0) ? numx_q[OUT_BITS-1:0] : '0;
			centroid_y     <= (den_q != '0) ? numy_q[OUT_BITS-1:0] : '0;
			centroid_valid <= (den_q != '0);
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller.
	always_comb begin
		status.last_acc = vld_s2 && last_s2;
		status.div_last = (cnt_q == DIV_CNT_BITS'(DIVIDEND_BITS - 1));
		status.out_free = !out_valid_q || !out_stall;
	end

endmodule

/* hdl/peak_neighbourhood_centroid_core.sv */
// Throughput: one pixel per clock while a frame is being summed.
// After the edge that takes the last pixel, the result passes two pipeline stages, a load step,
// 41 divider steps (one quotient bit per cycle over a 41-bit dividend) and the output register;
// input is stalled meanwhile.
// Reset (arst_n, asynchronous): sums, position counters and control clear;
// frame_width returns to 1024 and the peak registers to zero.
module peak_neighbourhood_centroid_core import pnc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic                      end_of_frame,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [OUT_BITS-1:0]       centroid_x,
	output logic [OUT_BITS-1:0]       centroid_y,
	output logic                      centroid_valid,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	pnc_cmd_t    cmd;
	pnc_status_t status;

	// Sequencing of accumulation, division and delivery.
	pnc_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.end_of_frame (end_of_frame),
		.in_stall     (in_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Selection, sums, divider and output register.
	pnc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_value    (pixel_value),
		.end_of_frame   (end_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.centroid_valid (centroid_valid)
	);

endmodule

/* hdl/pnc_checker.sv */
`include "peak_neighbourhood_centroid_core_macros.svh"

module pnc_checker import pnc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  end_of_frame,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [OUT_BITS-1:0]   centroid_x,
	input logic [OUT_BITS-1:0]   centroid_y,
	input logic                  centroid_valid
);

	// A held result keeps its value.
	`PNC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(centroid_x) && $stable(centroid_y), "stalled result changed")

	// An empty neighbourhood reports a zero centroid.
	`PNC_ASSERT_IMP(a_zero_sum, out_valid && !centroid_valid, centroid_x == '0 && centroid_y == '0, "zero weight sum with non-zero centroid")

	// The last pixel of a frame closes the input until the result is out.
	`PNC_ASSERT_NXT(a_eof_stall, in_valid && !in_stall && end_of_frame, in_stall, "request taken after end of frame")

	// A new result only appears while the input is closed.
	`PNC_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_stall), "result without a finished frame")

endmodule

bind peak_neighbourhood_centroid_core pnc_checker u_pnc_checker (.*);

/* sim/tb.sv */
module tb;
	import pnc_pkg::*;

	localparam int MAX_COLUMNS   = 1 << POS_BITS;
	localparam int DRAIN_CYCLES  = 50;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int RANDOM_FRAMES = 40;
	localparam int HOLD_CYCLES   = 1000;
	localparam int TIMEOUT_TIME  = 3_200_000;

	typedef enum logic {ROW_SETUP, ROW_PIXEL} row_kind_t;

	typedef struct {
		logic [OUT_BITS-1:0] x;
		logic [OUT_BITS-1:0] y;
		logic                ok;
	} centroid_t;

	// One directed step: either a full register setup or one pixel request.
	typedef struct {
		row_kind_t             kind;
		logic [WIDTH_BITS-1:0] width;
		logic [PIXEL_BITS-1:0] value;
		logic [POS_BITS-1:0]   px;
		logic [POS_BITS-1:0]   py;
		logic                  eof;
		logic                  typed;
		logic [OUT_BITS-1:0]   ex;
		logic [OUT_BITS-1:0]   ey;
		logic                  ev;
	} directed_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [PIXEL_BITS-1:0]     pixel_value;
	logic                      end_of_frame;
	logic                      out_valid;
	logic                      out_stall;
	logic [OUT_BITS-1:0]       centroid_x;
	logic [OUT_BITS-1:0]       centroid_y;
	logic                      centroid_valid;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// Shadow registers and scan state of the predictor.
	logic [WIDTH_BITS-1:0] shadow_width  = FRAME_WIDTH_RESET;
	logic [PIXEL_BITS-1:0] shadow_peak   = '0;
	logic [POS_BITS-1:0]   shadow_peak_x = '0;
	logic [POS_BITS-1:0]   shadow_peak_y = '0;
	logic [POS_BITS-1:0]   scan_col      = '0;
	logic [POS_BITS-1:0]   scan_row      = '0;
	logic [WSUM_BITS-1:0]  weight_total  = '0;
	logic [PSUM_BITS-1:0]  col_moment    = '0;
	logic [PSUM_BITS-1:0]  row_moment    = '0;

	centroid_t   pending_centroids[$];
	int unsigned error_count  = 0;
	int          idle_pct     = 0;
	int          stall_pct    = 0;
	int          hold_request = 0;

	directed_row_t directed_rows [22] = '{
		// Straight after reset: peak value zero lets any pixel at the origin count.
		'{ROW_PIXEL, 13'd0, 16'h1234, 12'd0, 12'd0, 1'b1, 1'b1, 20'd0, 20'd0, 1'b1},
		// A zero pixel gives a zero weight sum.
		'{ROW_PIXEL, 13'd0, 16'h0000, 12'd0, 12'd0, 1'b1, 1'b1, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b1, 1'b1, 20'd0, 20'd0, 1'b1},
		// A full 3x3 patch around (1,1) centres on exactly 1.0 in both axes.
		'{ROW_SETUP, 13'd3, 16'hFFFF, 12'd1, 12'd1, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hFFFF, 12'd0, 12'd0, 1'b1, 1'b1, 20'd256, 20'd256, 1'b1},
		// Either side of the 0.98 threshold for a full-scale peak, widest row.
		'{ROW_SETUP, 13'd4096, 16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'd64224, 12'd0, 12'd0, 1'b1, 1'b1, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'd64225, 12'd0, 12'd0, 1'b1, 1'b1, 20'd0, 20'd0, 1'b1},
		// Width zero behaves as width one: every pixel starts a new row.
		'{ROW_SETUP, 13'd0, 16'h8000, 12'd0, 12'd2, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'h8000, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'd32113, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'd32112, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'h0001, 12'd0, 12'd0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0},
		'{ROW_PIXEL, 13'd0, 16'hC000, 12'd0, 12'd0, 1'b1, 1'b0, 20'd0, 20'd0, 1'b0}
	};

	peak_neighbourhood_centroid_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.end_of_frame   (end_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.centroid_valid (centroid_valid),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_TIME);
		$display("peak_neighbourhood_centroid_core verification failed");
		$finish;
	end

	// Apply one accepted pixel to the predictor and queue the centroid it produces.
	task automatic accumulate_pixel(input logic [PIXEL_BITS-1:0] pix, input logic eof);
		int              dx;
		int              dy;
		int unsigned     dist2;
		longint unsigned scaled;
		centroid_t       result;
		dx = int'(shadow_peak_x) - int'(scan_col);
		dy = int'(shadow_peak_y) - int'(scan_row);
		dist2 = dx * dx + dy * dy;
		if (longint'(pix) * VALUE_NUM >= longint'(shadow_peak) * VALUE_DEN && dist2 < 9) begin
			weight_total = weight_total + pix;
			col_moment   = col_moment + pix * scan_col;
			row_moment   = row_moment + pix * scan_row;
		end
		if (eof) begin
			result = '{x: '0, y: '0, ok: 1'b0};
			if (weight_total != 0) begin
				scaled = col_moment;
				scaled = (scaled << FRACTION_BITS) / weight_total;
				result.x = scaled[OUT_BITS-1:0];
				scaled = row_moment;
				scaled = (scaled << FRACTION_BITS) / weight_total;
				result.y = scaled[OUT_BITS-1:0];
				result.ok = 1'b1;
			end
			pending_centroids.push_back(result);
			scan_col     = '0;
			scan_row     = '0;
			weight_total = '0;
			col_moment   = '0;
			row_moment   = '0;
		end else if (int'(scan_col) + 1 >= int'(shadow_width) || int'(scan_col) + 1 >= MAX_COLUMNS) begin
			scan_col = '0;
			scan_row = scan_row + 1'b1;
		end else begin
			scan_col = scan_col + 1'b1;
		end
	endtask

	// Offer one pixel request, with random idle cycles first, and wait until it is taken.
	task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic eof);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pixel_value  <= pix;
		end_of_frame <= eof;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		accumulate_pixel(pix, eof);
	endtask

	// Stop offering requests and let every outstanding centroid drain out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_centroids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers once the block has gone quiet.
	task automatic program_frame(input logic [WIDTH_BITS-1:0] width,
			input logic [PIXEL_BITS-1:0] peak, input logic [POS_BITS-1:0] px,
			input logic [POS_BITS-1:0] py);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= CFG_DATA_BITS'(width);
		@(posedge clk);
		cfg_index <= REG_PEAK_VALUE;
		cfg_data  <= CFG_DATA_BITS'(peak);
		@(posedge clk);
		cfg_index <= REG_PEAK_X;
		cfg_data  <= CFG_DATA_BITS'(px);
		@(posedge clk);
		cfg_index <= REG_PEAK_Y;
		cfg_data  <= CFG_DATA_BITS'(py);
		@(posedge clk);
		cfg_write <= 1'b0;
		shadow_width  = width;
		shadow_peak   = peak;
		shadow_peak_x = px;
		shadow_peak_y = py;
	endtask

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Compare each accepted result with the oldest predicted centroid.
	always @(negedge clk) begin : centroid_check
		centroid_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_centroids.size() == 0) begin
				error_count++;
				$error("centroid result with no frame outstanding");
			end else begin
				due = pending_centroids.pop_front();
				if (centroid_x !== due.x) begin
					error_count++;
					$error("centroid_x: expected %0d, got %0d", due.x, centroid_x);
				end
				if (centroid_y !== due.y) begin
					error_count++;
					$error("centroid_y: expected %0d, got %0d", due.y, centroid_y);
				end
				if (centroid_valid !== due.ok) begin
					error_count++;
					$error("centroid_valid: expected %0d, got %0d", due.ok, centroid_valid);
				end
			end
		end
	end

	initial begin
		int                    r;
		int                    eff_w;
		int                    len;
		int                    frames;
		int                    thr;
		int                    group;
		int                    random_items;
		int                    random_frames;
		logic [WIDTH_BITS-1:0] w;
		logic [PIXEL_BITS-1:0] pk;
		logic [PIXEL_BITS-1:0] pix;
		logic [POS_BITS-1:0]   px;
		logic [POS_BITS-1:0]   py;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		pixel_value  = '0;
		end_of_frame = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_FRAME_WIDTH;
		cfg_data     = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; typed rows replace the predicted centroid with a fixed one.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETUP) begin
				program_frame(directed_rows[i].width, directed_rows[i].value,
					directed_rows[i].px, directed_rows[i].py);
			end else begin
				send_pixel(directed_rows[i].value, directed_rows[i].eof);
				if (directed_rows[i].typed)
					pending_centroids[pending_centroids.size() - 1] =
						'{x: directed_rows[i].ex, y: directed_rows[i].ey, ok: directed_rows[i].ev};
			end
		end

		// Random groups: one register setting, then a few frames back to back.
		group = 0;
		random_items = 0;
		random_frames = 0;
		while (random_items < RANDOM_ITEMS || random_frames < RANDOM_FRAMES) begin
			case (group % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			r = $urandom_range(0, 99);
			if (r < 70)
				w = WIDTH_BITS'($urandom_range(1, 8));
			else if (r < 80)
				w = WIDTH_BITS'($urandom_range(9, 24));
			else if (r < 90) begin
				case ($urandom_range(0, 3))
					0: w = 13'd0;
					1: w = 13'd4096;
					2: w = 13'd8191;
					default: w = WIDTH_BITS'($urandom_range(4097, 8191));
				endcase
			end else
				w = WIDTH_BITS'($urandom_range(25, 4096));
			eff_w = (w == 0) ? 1 : ((w > MAX_COLUMNS) ? MAX_COLUMNS : int'(w));
			r = $urandom_range(0, 99);
			if (r < 25)
				pk = '0;
			else if (r < 35)
				pk = '1;
			else
				pk = PIXEL_BITS'($urandom_range(0, 65535));
			if (eff_w <= 24) begin
				px = POS_BITS'($urandom_range(0, eff_w + 1));
				py = POS_BITS'($urandom_range(0, 5));
			end else begin
				px = $urandom_range(0, 1) ? POS_BITS'($urandom_range(0, 6))
					: POS_BITS'($urandom_range(0, 4095));
				py = POS_BITS'($urandom_range(0, 2));
			end
			program_frame(w, pk, px, py);
			thr = (VALUE_DEN * int'(pk) + VALUE_NUM - 1) / VALUE_NUM;

			// One group runs into a long result hold-off so the input backs up.
			if (group == 4) begin
				hold_request = HOLD_CYCLES;
				frames = 4;
			end else begin
				frames = $urandom_range(1, 4);
			end
			for (int f = 0; f < frames; f++) begin
				if (eff_w <= 24)
					len = eff_w * (int'(py) + $urandom_range(0, 4)) + $urandom_range(1, eff_w);
				else
					len = $urandom_range(1, 40);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						pix = PIXEL_BITS'($urandom_range(thr, 65535));
					else if (r < 55)
						pix = PIXEL_BITS'(thr);
					else if (r < 62 && thr > 0)
						pix = PIXEL_BITS'(thr - 1);
					else
						pix = PIXEL_BITS'($urandom_range(0, 65535));
					send_pixel(pix, k == len - 1);
					random_items++;
				end
				random_frames++;
			end
			group++;
		end

		wait_idle();
		if (error_count == 0)
			$display("peak_neighbourhood_centroid_core verification clean");
		else
			$display("peak_neighbourhood_centroid_core verification failed");
		$finish;
	end

endmodule
